// File: rtl/core/mpq_pkg.sv
// Package for the min priority queue: request and result item types,
// status and request codes, and the control bundle sent to every cell.
// No dependencies; used by mpq_cell and min_priority_queue.
package mpq_pkg;

  // Fixed field widths of the request and result items.
  localparam int KEY_W = 32;
  localparam int PAY_W = 16;
  localparam int OCC_W = 7;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // One held entry of the queue.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic capture;  // Compare the held key against the request key.
    logic ins;      // Apply an insert: shift the larger tail one place right.
    logic ext;      // Apply an extract: shift the whole row one place left.
  } cell_ctl_t;

endpackage

// File: rtl/core/min_priority_queue.sv
// Top level of the min priority queue: request register, entry counter,
// result register and a row of CAPACITY mpq_cell instances.
// Depends on mpq_pkg and mpq_cell.
//
// Usage: a request (insert key/payload, or extract the minimum) is
// transferred at a rising edge where start is high and busy is low.
// The entries sit in a row of cells kept in key order, oldest first among
// equal keys, so the head cell always holds the next entry to leave.
// Each request is handled in a compare step, where every cell compares
// its key with the request key, then a shift step, where the row shifts
// by one place (right of the insertion point for an insert, left for an
// extract). busy is high during the shift, so no new request is taken
// until then. The result is registered after the shift, for exactly one
// cycle, marked by out_valid; the receiver cannot stall it. The result
// carries the status, the extracted entry (zero unless an extract was
// done) and the entry count after the request. An insert into a full
// queue and an extract from an empty one leave the contents unchanged.
// A synchronous reset empties the queue at once; no clearing pass.
module min_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mpq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output mpq_pkg::out_item_t out_item
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request register and stage flag.
  in_item_t         req_r;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic      accept;
  logic      is_ins;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  entry_t    req_entry;

  // Row wiring between neighboring cells.
  entry_t cell_entry [CAPACITY];
  logic   cell_valid [CAPACITY];
  logic   cell_gt    [CAPACITY];

  assign accept = start && !pend_r;
  assign busy   = pend_r;
  assign is_ins = (req_r.req_type == REQ_INSERT);
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // The compare runs in the transfer cycle against the incoming key; the
  // shift runs in the following cycle from the registered request.
  assign req_entry.key     = accept ? in_item.key : req_r.key;
  assign req_entry.payload = req_r.payload;

  assign ctl.capture = accept;
  assign ctl.ins     = pend_r && is_ins && !full;
  assign ctl.ext     = pend_r && !is_ins && !empty;

  // Row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    logic   left_valid;
    logic   left_gt;
    entry_t right_entry;
    logic   right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_gt    = 1'b0;
    end else begin : g_mid_l
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_entry   (req_entry),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Count update and result formation in the shift cycle.
  always_comb begin
    pend_nxt      = accept;
    count_nxt     = count_r;
    out_valid_nxt = pend_r;
    out_item_nxt  = '0;
    if (pend_r) begin
      if (is_ins) begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          out_item_nxt.status = ST_DONE;
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.status      = ST_DONE;
          out_item_nxt.out_key     = cell_entry[0].key;
          out_item_nxt.out_payload = cell_entry[0].payload;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      out_item_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/core/mpq_cell.sv
// One cell of the sorted row: holds one entry, its valid bit and the
// result of comparing its key against the pending request key.
// Depends on mpq_pkg.
module mpq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mpq_pkg::cell_ctl_t ctl,
  input  mpq_pkg::entry_t   new_entry,
  input  mpq_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  logic              left_gt,
  input  mpq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  output mpq_pkg::entry_t   entry,
  output logic              valid,
  output logic              gt
);
  import mpq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   gt_r, gt_nxt;

  // An empty cell counts as holding an infinitely large key, so an insert
  // lands in the first cell whose key is strictly larger or that is empty.
  always_comb begin
    gt_nxt = gt_r;
    if (ctl.capture) begin
      gt_nxt = !valid_r || (entry_r.key > new_entry.key);
    end
  end

  // Shift in from a neighbor or take the new entry.
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.ins && gt_r) begin
      if (left_gt) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else begin
        entry_nxt = new_entry;
        valid_nxt = 1'b1;
      end
    end else if (ctl.ext) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      gt_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      gt_r    <= gt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;
  assign gt    = gt_r;

endmodule
